// ===== hw/rtl/vafbc_pkg.sv =====
// Shared types and constants for the vehicle acceleration filter / brake check.
// Holds the register index codes, the configuration struct and pipeline stage types.
// No dependencies; imported by vafbc_csr and the top level.
`default_nettype none

package vafbc_pkg;

   // Register file addressing
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_COEF_B0         = 3'd0,
      CSR_COEF_B1         = 3'd1,
      CSR_COEF_B2         = 3'd2,
      CSR_COEF_A1         = 3'd3,
      CSR_COEF_A2         = 3'd4,
      CSR_SPEED_FACTOR    = 3'd5,
      CSR_SPEED_THRESHOLD = 3'd6
   } csr_idx_type;

   // Threat level codes
   typedef enum logic [1:0] {
      THREAT_NONE   = 2'd0,
      THREAT_LOW    = 2'd1,
      THREAT_MEDIUM = 2'd2,
      THREAT_HIGH   = 2'd3
   } threat_type;

   // Q2.14 unity and rounding constants
   localparam logic signed [15:0] COEF_UNITY   = 16'sd16384;
   localparam logic        [15:0] FACTOR_UNITY = 16'd16384;
   localparam int unsigned        Q14_SHIFT    = 14;

   // Configuration registers as seen by the datapath
   typedef struct packed {
      logic signed [15:0] coef_b0;
      logic signed [15:0] coef_b1;
      logic signed [15:0] coef_b2;
      logic signed [15:0] coef_a1;
      logic signed [15:0] coef_a2;
      logic        [15:0] speed_factor;
      logic        [15:0] speed_threshold;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      coef_b0:         COEF_UNITY,
      coef_b1:         16'sd0,
      coef_b2:         16'sd0,
      coef_a1:         16'sd0,
      coef_a2:         16'sd0,
      speed_factor:    FACTOR_UNITY,
      speed_threshold: 16'd0
   };

   // Stage 1: feed-forward products and raw speed product
   typedef struct packed {
      logic signed [31:0] prod_b0;
      logic signed [31:0] prod_b1;
      logic signed [31:0] prod_b2;
      logic        [31:0] prod_speed;
      logic signed [15:0] decel_request;
      logic               brake_enable;
      logic        [1:0]  threat_level;
   } stage1_type;

   // Stage 2: feed-forward sum, compensated speed and brake decision
   typedef struct packed {
      logic signed [33:0] ff_sum;
      logic        [15:0] speed_out;
      logic signed [15:0] decel_request;
      logic               brake_enable;
      logic               brake_active;
   } stage2_type;

endpackage : vafbc_pkg

`default_nettype wire

// ===== hw/rtl/vafbc_csr.sv =====
// Configuration register file for the acceleration filter / brake check.
// Plain write port, no read-back; writes to unused indexes are dropped.
// Depends on vafbc_pkg.
`default_nettype none

module vafbc_csr
   import vafbc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output cfg_type                    cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COEF_B0:         cfg_in.coef_b0         = $signed(csr_wdata);
            CSR_COEF_B1:         cfg_in.coef_b1         = $signed(csr_wdata);
            CSR_COEF_B2:         cfg_in.coef_b2         = $signed(csr_wdata);
            CSR_COEF_A1:         cfg_in.coef_a1         = $signed(csr_wdata);
            CSR_COEF_A2:         cfg_in.coef_a2         = $signed(csr_wdata);
            CSR_SPEED_FACTOR:    cfg_in.speed_factor    = csr_wdata;
            CSR_SPEED_THRESHOLD: cfg_in.speed_threshold = csr_wdata;
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule : vafbc_csr

`default_nettype wire

// ===== hw/rtl/vehicle_accel_filter_brake_check_top.sv =====
// Top level of the vehicle acceleration filter and collision brake check.
// Three-stage pipeline around a direct form I biquad; uses vafbc_csr.
// Depends on vafbc_pkg.
//
// Usage:
//   req_* is a valid/ready channel carrying one vehicle sample per word:
//   speed, acceleration, driver deceleration request, brake enable and
//   threat level. rsp_* is a valid/ready channel returning one word per
//   sample: compensated speed, filtered acceleration, driver acceleration
//   and the brake-active flag. csr_* is a write-only register port for the
//   five filter coefficients, the speed factor and the speed threshold;
//   write it only while no sample is in flight.
//   An accepted sample passes the stage 1 and stage 2 registers into the
//   output register, where rsp_valid rises. One word per cycle is accepted
//   back to back while the receiver does not stall; the rate is set by the
//   output feedback loop, where the a1 product of the last output, the add
//   and the saturation all close in one combinational path; the a2 product
//   is registered ahead. When the receiver stalls, rsp holds its word and
//   the whole pipeline freezes, so req_ready drops in the same cycle.
//   Synchronous reset empties the pipeline, clears the filter history and
//   loads the register defaults (unity b0 and speed factor, others zero).
`default_nettype none

module vehicle_accel_filter_brake_check_top
   import vafbc_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   // sample input
   input  wire logic                  req_valid,
   output      logic                  req_ready,
   input  wire logic        [15:0]    req_speed,
   input  wire logic signed [15:0]    req_accel,
   input  wire logic signed [15:0]    req_decel_request,
   input  wire logic                  req_brake_enable,
   input  wire logic        [1:0]     req_threat_level,
   // result output
   output      logic                  rsp_valid,
   input  wire logic                  rsp_ready,
   output      logic        [15:0]    rsp_speed_out,
   output      logic signed [15:0]    rsp_accel_filtered,
   output      logic signed [15:0]    rsp_driver_accel,
   output      logic                  rsp_brake_active,
   // configuration
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type cfg;

   vafbc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // Pipeline control: all stages move together unless the output is stalled
   logic advance;
   logic req_fire;
   logic out_load;

   logic       v1_ff, v1_in;
   logic       v2_ff, v2_in;
   logic       rsp_valid_ff, rsp_valid_in;
   stage1_type s1_ff, s1_in;
   stage2_type s2_ff, s2_in;

   // Filter history
   logic signed [15:0] in_hist_1_ff, in_hist_1_in;
   logic signed [15:0] in_hist_2_ff, in_hist_2_in;
   logic signed [15:0] out_hist_1_ff, out_hist_1_in;
   logic signed [15:0] out_hist_2_ff, out_hist_2_in;
   logic signed [31:0] prod_a2_ff, prod_a2_in;

   // Output payload
   logic        [15:0] speed_out_ff, speed_out_in;
   logic signed [15:0] accel_filt_ff, accel_filt_in;
   logic signed [15:0] driver_accel_ff, driver_accel_in;
   logic               brake_active_ff, brake_active_in;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;
   assign req_fire  = req_valid && advance;
   assign out_load  = advance && v2_ff;

   // Stage 1: feed-forward products, speed product, input history shift
   always_comb begin
      s1_in.prod_b0       = req_accel * cfg.coef_b0;
      s1_in.prod_b1       = in_hist_1_ff * cfg.coef_b1;
      s1_in.prod_b2       = in_hist_2_ff * cfg.coef_b2;
      s1_in.prod_speed    = req_speed * cfg.speed_factor;
      s1_in.decel_request = req_decel_request;
      s1_in.brake_enable  = req_brake_enable;
      s1_in.threat_level  = req_threat_level;
      v1_in               = advance ? req_valid : v1_ff;
      in_hist_1_in        = req_fire ? req_accel    : in_hist_1_ff;
      in_hist_2_in        = req_fire ? in_hist_1_ff : in_hist_2_ff;
   end

   // Stage 2: feed-forward sum, speed rounding/saturation, threat check
   logic [32:0] speed_rnd;
   logic [18:0] speed_q;
   logic [15:0] speed_sat;
   logic        medium_hit;

   always_comb begin
      speed_rnd  = {1'b0, s1_ff.prod_speed} + 33'd8192;
      speed_q    = speed_rnd[32:Q14_SHIFT];
      speed_sat  = (|speed_q[18:16]) ? 16'hFFFF : speed_q[15:0];
      medium_hit = (s1_ff.threat_level == THREAT_MEDIUM) &&
                   (speed_sat > cfg.speed_threshold);

      s2_in.ff_sum        = 34'(s1_ff.prod_b0) + 34'(s1_ff.prod_b1) + 34'(s1_ff.prod_b2);
      s2_in.speed_out     = speed_sat;
      s2_in.decel_request = s1_ff.decel_request;
      s2_in.brake_enable  = s1_ff.brake_enable;
      s2_in.brake_active  = s1_ff.brake_enable &&
                            (medium_hit || (s1_ff.threat_level == THREAT_HIGH));
      v2_in               = advance ? v1_ff : v2_ff;
   end

   // Stage 3: feedback terms, round to Q8.8, saturate, output history shift
   logic signed [31:0] prod_a1;
   logic signed [34:0] acc;
   logic signed [34:0] acc_rnd;
   logic signed [20:0] acc_q;
   logic signed [15:0] y_sat;

   always_comb begin
      prod_a1 = out_hist_1_ff * cfg.coef_a1;
      acc     = 35'(s2_ff.ff_sum) + 35'(prod_a2_ff) + 35'(prod_a1);
      acc_rnd = acc + 35'sd8192;
      acc_q   = acc_rnd[34:Q14_SHIFT];
      if (acc_q > 21'sd32767) begin
         y_sat = 16'sh7FFF;
      end else if (acc_q < -21'sd32768) begin
         y_sat = 16'sh8000;
      end else begin
         y_sat = acc_q[15:0];
      end

      out_hist_1_in = out_load ? y_sat         : out_hist_1_ff;
      out_hist_2_in = out_load ? out_hist_1_ff : out_hist_2_ff;
      // a2 product of whatever will be the two-back output next cycle
      prod_a2_in    = out_hist_2_in * cfg.coef_a2;

      speed_out_in    = out_load ? s2_ff.speed_out    : speed_out_ff;
      accel_filt_in   = out_load ? y_sat              : accel_filt_ff;
      driver_accel_in = out_load ? (s2_ff.brake_enable ? s2_ff.decel_request : y_sat)
                                 : driver_accel_ff;
      brake_active_in = out_load ? s2_ff.brake_active : brake_active_ff;
      rsp_valid_in    = advance ? v2_ff : rsp_valid_ff;
   end

   // Control and history registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff         <= 1'b0;
         v2_ff         <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         in_hist_1_ff  <= '0;
         in_hist_2_ff  <= '0;
         out_hist_1_ff <= '0;
         out_hist_2_ff <= '0;
         prod_a2_ff    <= '0;
      end else begin
         v1_ff         <= v1_in;
         v2_ff         <= v2_in;
         rsp_valid_ff  <= rsp_valid_in;
         in_hist_1_ff  <= in_hist_1_in;
         in_hist_2_ff  <= in_hist_2_in;
         out_hist_1_ff <= out_hist_1_in;
         out_hist_2_ff <= out_hist_2_in;
         prod_a2_ff    <= prod_a2_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_fire) begin
         s1_ff <= s1_in;
      end
      if (advance && v1_ff) begin
         s2_ff <= s2_in;
      end
      speed_out_ff    <= speed_out_in;
      accel_filt_ff   <= accel_filt_in;
      driver_accel_ff <= driver_accel_in;
      brake_active_ff <= brake_active_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_speed_out      = speed_out_ff;
   assign rsp_accel_filtered = accel_filt_ff;
   assign rsp_driver_accel   = driver_accel_ff;
   assign rsp_brake_active   = brake_active_ff;

endmodule : vehicle_accel_filter_brake_check_top

`default_nettype wire

// ===== hw/rtl/vafbc_checker.sv =====
// Port-level checks for the acceleration filter / brake check top level.
// Bound to vehicle_accel_filter_brake_check_top; no package needed.
`default_nettype none

module vafbc_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  req_valid,
   input wire logic                  req_ready,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic        [15:0]    rsp_speed_out,
   input wire logic signed [15:0]    rsp_accel_filtered,
   input wire logic signed [15:0]    rsp_driver_accel,
   input wire logic                  rsp_brake_active
);

   // Result word holds while the receiver stalls
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_speed_out) &&
         $stable(rsp_accel_filtered) && $stable(rsp_driver_accel) &&
         $stable(rsp_brake_active))
      else $error("result word changed while stalled");

   // Reset empties the output register
   assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // A stalled output freezes the pipeline, so no new sample is taken
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("sample accepted while output stalled");

   // With the output register empty the block is always ready for a sample
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input blocked with empty output");

   // A sample is refused only while the output register holds a word
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_ready |-> rsp_valid)
      else $error("sample refused with empty output");

endmodule : vafbc_checker

bind vehicle_accel_filter_brake_check_top vafbc_checker u_vafbc_checker (.*);

`default_nettype wire
